FILE: rtl/tdpt_pkg.sv
// Shared types, constants and microcode ROM for the trial division prime test.
package tdpt_pkg;

    localparam int NUM_WIDTH_DEF = 32;
    localparam int CAND_W        = 32;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_CHK_LT2  = 4'd1,
        S_CHK_LT4  = 4'd2,
        S_CHK_EVEN = 4'd3,
        S_LOOP     = 4'd4,
        S_WAIT     = 4'd5,
        S_REM_TEST = 4'd6,
        S_RES0     = 4'd7,
        S_RES1     = 4'd8
    } step_t;

    // Branch conditions
    typedef enum logic [2:0] {
        C_IN_VALID    = 3'd0,
        C_N_LT2       = 3'd1,
        C_N_LT4       = 3'd2,
        C_N_EVEN      = 3'd3,
        C_SQ_GT_N     = 3'd4,
        C_MOD_BUSY    = 3'd5,
        C_REM_ZERO    = 3'd6,
        C_OUT_BLOCKED = 3'd7
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t jt;        // taken when cond holds
        step_t jf;        // taken otherwise
        logic  accept;    // input channel open
        logic  init_d;    // d = 3, sq = 9
        logic  start_mod; // launch remainder unit
        logic  step_d;    // d += 2, sq updated
        logic  wr_out;    // load result word
        logic  out_val;   // result value to load
    } ctrl_word_t;

    // Control store
    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t cw;
        cw = '{cond: C_IN_VALID, jt: S_IDLE, jf: S_IDLE, default: 1'b0};
        case (s)
            S_IDLE:
            begin
                cw.cond = C_IN_VALID; cw.jt = S_CHK_LT2; cw.jf = S_IDLE;
                cw.accept = 1'b1;
            end
            S_CHK_LT2:
            begin
                cw.cond = C_N_LT2; cw.jt = S_RES0; cw.jf = S_CHK_LT4;
            end
            S_CHK_LT4:
            begin
                cw.cond = C_N_LT4; cw.jt = S_RES1; cw.jf = S_CHK_EVEN;
            end
            S_CHK_EVEN:
            begin
                cw.cond = C_N_EVEN; cw.jt = S_RES0; cw.jf = S_LOOP;
                cw.init_d = 1'b1;
            end
            S_LOOP:
            begin
                cw.cond = C_SQ_GT_N; cw.jt = S_RES1; cw.jf = S_WAIT;
                cw.start_mod = 1'b1;
            end
            S_WAIT:
            begin
                cw.cond = C_MOD_BUSY; cw.jt = S_WAIT; cw.jf = S_REM_TEST;
            end
            S_REM_TEST:
            begin
                cw.cond = C_REM_ZERO; cw.jt = S_RES0; cw.jf = S_LOOP;
                cw.step_d = 1'b1;
            end
            S_RES0:
            begin
                cw.cond = C_OUT_BLOCKED; cw.jt = S_RES0; cw.jf = S_IDLE;
                cw.wr_out = 1'b1; cw.out_val = 1'b0;
            end
            S_RES1:
            begin
                cw.cond = C_OUT_BLOCKED; cw.jt = S_RES1; cw.jf = S_IDLE;
                cw.wr_out = 1'b1; cw.out_val = 1'b1;
            end
            default:
            begin
                cw.cond = C_IN_VALID; cw.jt = S_IDLE; cw.jf = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/tdpt_mod_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module tdpt_mod_unit #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output logic                 busy,
    output logic [NUM_WIDTH-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] shift_reg, shift_next;
    logic [NUM_WIDTH-1:0] div_reg, div_next;
    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;

    // Shift in next dividend bit, subtract when it fits
    assign trial = {rem_reg, shift_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(NUM_WIDTH);
            busy_next  = 1'b1;
            rem_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[NUM_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = diff[NUM_WIDTH-1:0];
            else
                rem_next = trial[NUM_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/trial_division_prime_test.sv
// Top level: microcoded trial division primality tester.
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------
//  input   | in_valid/in_stall  | candidate (32 bits, low NUM_WIDTH used)
//  output  | out_valid/out_stall| is_prime (1 bit)
//
// After accept, words below 2 give 0, 2 and 3 give 1, and even words give 0.
// Odd words try odd divisors d = 3, 5, ... while d*d <= candidate: 0 if one
// divides, else 1; the remainder unit works one bit a cycle.
// A blocked result step waits until the output register frees up.
// Reset clears the step counter, remainder unit control and output valid.
// A held result does not block the next word being taken and worked on;
// only the final result write waits for the output register to free up.
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CAND_W-1:0] candidate,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              is_prime,
    output logic              out_valid,
    input  logic              out_stall
);

    localparam int SQ_W = NUM_WIDTH + 2;

    step_t                step_reg, step_next;
    ctrl_word_t           cw;
    logic                 cond_true;
    logic                 out_blocked;
    logic                 in_accept;
    logic                 out_load;

    logic [NUM_WIDTH+CAND_W-1:0] cand_wide;
    logic [NUM_WIDTH-1:0] n_reg;
    logic [NUM_WIDTH-1:0] d_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 is_prime_reg;

    logic                 mod_busy;
    logic [NUM_WIDTH-1:0] mod_rem;

    // Remainder unit
    tdpt_mod_unit #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cw.start_mod),
        .dividend (n_reg),
        .divisor  (d_reg),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    // Control word fetch
    assign cw          = ucode(step_reg);
    assign out_blocked = out_valid_reg & out_stall;
    assign in_accept   = cw.accept & in_valid;
    assign out_load    = cw.wr_out & ~out_blocked;
    assign cand_wide   = {{NUM_WIDTH{1'b0}}, candidate};

    // Branch condition select
    always_comb
    begin
        case (cw.cond)
            C_IN_VALID:    cond_true = in_valid;
            C_N_LT2:       cond_true = {1'b0, n_reg} < (NUM_WIDTH + 1)'(2);
            C_N_LT4:       cond_true = {1'b0, n_reg} < (NUM_WIDTH + 1)'(4);
            C_N_EVEN:      cond_true = ~n_reg[0];
            C_SQ_GT_N:     cond_true = sq_reg > {2'b00, n_reg};
            C_MOD_BUSY:    cond_true = mod_busy;
            C_REM_ZERO:    cond_true = mod_rem == '0;
            C_OUT_BLOCKED: cond_true = out_blocked;
            default:       cond_true = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        step_next = cond_true ? cw.jt : cw.jf;
    end

    // Output valid next
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            n_reg <= cand_wide[NUM_WIDTH-1:0];
        if (cw.init_d)
        begin
            d_reg  <= NUM_WIDTH'(3);
            sq_reg <= SQ_W'(9);
        end
        else if (cw.step_d)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            d_reg  <= d_reg + NUM_WIDTH'(2);
            sq_reg <= sq_reg + {d_reg, 2'b00} + SQ_W'(4);
        end
        if (out_load)
            is_prime_reg <= cw.out_val;
    end

    assign in_stall  = ~cw.accept;
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the trial division prime tester.
module testbench
    import tdpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 100;
    localparam int RAND_PER_PHASE = 250;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [CAND_W-1:0] candidate = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              is_prime;
    logic              out_valid;
    logic              out_stall = 1'b0;

    // words waiting to be offered, and verdicts waiting to come out
    logic [CAND_W-1:0] pending_q[$];
    bit                verdict_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_go = 1'b0;
    logic hold_off = 1'b0;

    int  mismatches = 0;
    int  words_in = 0;
    int  verdicts_checked = 0;
    int  primes_seen = 0;

    trial_division_prime_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .is_prime  (is_prime),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // expected verdict: small and even cases first, then odd divisors up to the square root
    function automatic bit prime_of(input logic [CAND_W-1:0] c);
        logic [63:0] n;
        logic [63:0] d;
        n = {32'd0, c} & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_WIDTH_DEF));
        if (n < 64'd2)
            return 1'b0;
        if (n < 64'd4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 64'd3; d * d <= n; d += 64'd2)
        begin
            if (n % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // random candidate, mostly small so the divisor loop stays short
    function automatic logic [CAND_W-1:0] pick_candidate();
        int unsigned sel;
        int unsigned p;
        logic [31:0] w;
        int unsigned small_odd[8] = '{3, 5, 7, 11, 13, 17, 19, 23};
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return $urandom_range(0, 1023);
        else if (sel < 60)
            return $urandom_range(0, 65535);
        else if (sel < 75)
        begin
            w = $urandom();
            w[0] = 1'b0;
            return w;
        end
        else if (sel < 90)
        begin
            // full width, but with a small odd factor
            p = small_odd[$urandom_range(0, 7)];
            return $urandom_range(1, 32'hFFFF_FFFF / p) * p;
        end
        else
            return $urandom_range(3, 255) * $urandom_range(3, 255);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // input driver: offers pending words, holds them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                verdict_q.push_back(prime_of(candidate));
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    candidate <= pending_q.pop_front();
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor: checks each verdict and drives the stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected verdict %0b", is_prime));
                else if (is_prime !== verdict_q[0])
                begin
                    report_mismatch($sformatf("is_prime %0b, expected %0b (word %0d)",
                        is_prime, verdict_q[0], verdicts_checked));
                    void'(verdict_q.pop_front());
                end
                else
                begin
                    if (verdict_q.pop_front())
                        primes_seen++;
                end
                verdicts_checked++;
            end
            out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // stimulus and end of run
    initial
    begin
        logic [CAND_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
                     32'd25, 32'd49, 32'd97, 32'd121, 32'd961, 32'd7919,
                     32'd63001, 32'd65521, 32'd65535, 32'd999983, 32'd1000001,
                     32'd16777213, 32'h8000_0000, 32'h8000_0001,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct <= 9;
        recv_idle_pct <= 86;
        foreach (directed[i])
            pending_q.push_back(directed[i]);
        repeat (RAND_PER_PHASE) pending_q.push_back(pick_candidate());
        drain();

        // the other way round
        send_idle_pct <= 86;
        recv_idle_pct <= 9;
        repeat (RAND_PER_PHASE) pending_q.push_back(pick_candidate());
        drain();

        // no idling, with a long output hold-off at the start
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_go = 1'b1;
        repeat (RAND_PER_PHASE) pending_q.push_back(pick_candidate());
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

        $display("Run covered %0d candidates and %0d verdicts, %0d of them prime.",
            words_in, verdicts_checked, primes_seen);
        $display("Both sides idled in turn, the output was held off and the input drained.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #200_000_000;
        $display("Timeout: run did not finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule
